// ===== rtl/cpt_pkg.sv =====
// cpt_pkg: shared types and constants for the channel/position corner-turn buffer.
// No dependencies; imported by channel_position_transpose, cpt_addr_ctrl and the bench.
package cpt_pkg;

    // Fixed field widths
    localparam int CNT_W  = 12;   // walk counters, wrap at 4096
    localparam int CFG_W  = 13;   // count registers and config data
    localparam int PROD_W = 26;   // channel_count * spatial_count, walk address
    localparam int OUT_W  = 32;   // data_in / data_out port width
    localparam int IDX_W  = 2;    // config register index

    // Config register indexes
    localparam logic [IDX_W-1:0] CFG_IDX_DIRECTION = 2'd0;
    localparam logic [IDX_W-1:0] CFG_IDX_CHANNELS  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_IDX_SPATIAL   = 2'd2;

    // Item opcodes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;

    // What the output beat carries
    typedef enum logic [1:0] {
        RES_ZERO,    // load beat or out-of-range read: all zero
        RES_EMPTY,   // fetch with no complete frame
        RES_DATA     // word read from the frame store
    } res_kind_t;

    typedef struct packed {
        res_kind_t  kind;
        logic       last;
    } res_t;

    // Effective configuration as seen by the walk control
    typedef struct packed {
        logic               mode;
        logic [CFG_W-1:0]   c_eff;
        logic [CFG_W-1:0]   s_eff;
        logic [PROD_W-1:0]  total;
    } cfg_t;

endpackage

// ===== rtl/channel_position_transpose.sv =====
// Corner-turn buffer for one frame of channel_count x spatial_count words.
// Input channel (in_valid/in_ready): func 0 loads data_in as the next source word,
// func 1 fetches the next word in transposed order. Every input beat yields exactly
// one output beat (out_valid/out_ready): zero for a load, the word for a fetch with
// last_of_frame on the final word, or empty_fetch with zero data if no full frame.
// direction_mode 0 turns channel-major into position-major, 1 the reverse.
// The user writes config (cfg_wr_en/cfg_index/cfg_data) only while the block is idle;
// the block does not enforce this. Input is held off during a write and the cycle after
// it while the frame size settles. An accepted beat passes the read stage, where its
// store read starts, and the output register. Throughput: one beat per cycle while
// out_ready is high and no config write holds off the input; each beat does one store
// access and the walk address takes one multiply-add. When the receiver stalls, one
// result waits in the output register and one in the read stage; then in_ready drops.
// Reset clears counters, flags and config (mode 0, counts 1). Store contents are
// undefined after reset; no clearing pass, a frame must be loaded before it is read.
// Depends on cpt_pkg, cpt_addr_ctrl and cpt_frame_mem.
module channel_position_transpose
    import cpt_pkg::*;
#(
    parameter int MAX_ELEMENTS = 4096,
    parameter int DATA_WIDTH   = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              func,
    input  logic [OUT_W-1:0]  data_in,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [OUT_W-1:0]  data_out,
    output logic              last_of_frame,
    output logic              empty_fetch
);

    localparam int AW  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int LCW = $clog2(MAX_ELEMENTS + 1);
    localparam int IW  = (DATA_WIDTH < OUT_W) ? DATA_WIDTH : OUT_W;

    // Config registers
    logic              mode_reg;
    logic [CFG_W-1:0]  chan_reg, spat_reg;
    logic [PROD_W-1:0] total_reg, total_next;
    logic              cfg_hold_reg;
    logic [CFG_W-1:0]  c_eff, s_eff;
    cfg_t              cfg;

    // Pipeline
    logic              accept;
    logic              s1_adv;
    logic              s1_valid_reg;
    res_t              s1_res_reg;
    logic              out_valid_reg;
    logic [OUT_W-1:0]  data_out_reg;
    logic              last_reg;
    logic              empty_reg;

    // Store interface
    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;
    res_t              res;

    // Effective counts and frame size
    always_comb
    begin
        c_eff      = (chan_reg == '0) ? CFG_W'(1) : chan_reg;
        s_eff      = (spat_reg == '0) ? CFG_W'(1) : spat_reg;
        total_next = PROD_W'(c_eff) * PROD_W'(s_eff);
        cfg.mode   = mode_reg;
        cfg.c_eff  = c_eff;
        cfg.s_eff  = s_eff;
        cfg.total  = total_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 1'b0;
            chan_reg     <= CFG_W'(1);
            spat_reg     <= CFG_W'(1);
            total_reg    <= PROD_W'(1);
            cfg_hold_reg <= 1'b0;
        end
        else
        begin
            total_reg    <= total_next;
            cfg_hold_reg <= cfg_wr_en;
            if (cfg_wr_en)
            begin
                if (cfg_index == CFG_IDX_DIRECTION)
                begin
                    mode_reg <= cfg_data[0];
                end
                if (cfg_index == CFG_IDX_CHANNELS)
                begin
                    chan_reg <= cfg_data;
                end
                if (cfg_index == CFG_IDX_SPATIAL)
                begin
                    spat_reg <= cfg_data;
                end
            end
        end
    end

    // Handshake
    assign s1_adv   = ~out_valid_reg | out_ready;
    assign in_ready = ~cfg_hold_reg & ~cfg_wr_en & (~s1_valid_reg | s1_adv);
    assign accept   = in_valid & in_ready;

    assign mem_wdata = DATA_WIDTH'(data_in[IW-1:0]);

    cpt_addr_ctrl #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .AW           (AW),
        .LCW          (LCW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .func      (func),
        .cfg       (cfg),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .res       (res)
    );

    cpt_frame_mem #(
        .DEPTH (MAX_ELEMENTS),
        .AW    (AW),
        .DW    (DATA_WIDTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Read stage: result tag waits for store data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_res_reg <= res;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid_reg)
        begin
            last_reg  <= s1_res_reg.last;
            empty_reg <= (s1_res_reg.kind == RES_EMPTY);
            if (s1_res_reg.kind == RES_DATA)
            begin
                data_out_reg <= OUT_W'(mem_rdata[IW-1:0]);
            end
            else
            begin
                data_out_reg <= '0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign data_out      = data_out_reg;
    assign last_of_frame = last_reg;
    assign empty_fetch   = empty_reg;

endmodule

// ===== rtl/cpt_frame_mem.sv =====
// cpt_frame_mem: frame store, one write port and one registered read port.
// Depends on nothing; instantiated by channel_position_transpose.
module cpt_frame_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem_arr [DEPTH];
    logic [DW-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_arr[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_arr[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/cpt_addr_ctrl.sv =====
// cpt_addr_ctrl: load count, transpose walk counters and frame-ready flag.
// Issues a store write per kept load and a read per in-range fetch. Depends on cpt_pkg.
module cpt_addr_ctrl
    import cpt_pkg::*;
#(
    parameter int MAX_ELEMENTS = 4096,
    parameter int AW           = 12,
    parameter int LCW          = 13
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic          func,
    input  cfg_t          cfg,
    output logic          mem_we,
    output logic [AW-1:0] mem_waddr,
    output logic          mem_re,
    output logic [AW-1:0] mem_raddr,
    output res_t          res
);

    localparam logic [PROD_W-1:0] MAX_P = PROD_W'(MAX_ELEMENTS);

    logic [LCW-1:0]   load_count_reg, load_count_next;
    logic [CNT_W-1:0] outer_reg, outer_next;
    logic [CNT_W-1:0] inner_reg, inner_next;
    logic             frame_ready_reg, frame_ready_next;

    logic              frame_ok;
    logic [PROD_W-1:0] lc_p;
    logic              ready_eff;
    logic [CFG_W-1:0]  lo, li;
    logic [PROD_W-1:0] addr_p;
    logic              addr_in;
    logic              inner_wrap, outer_wrap;
    logic              do_load, do_fetch;

    // Frame status and walk address
    always_comb
    begin
        frame_ok  = cfg.total <= MAX_P;
        lc_p      = PROD_W'(load_count_reg);
        ready_eff = frame_ready_reg | (frame_ok & (lc_p >= cfg.total));
        lo        = cfg.mode ? cfg.c_eff : cfg.s_eff;
        li        = cfg.mode ? cfg.s_eff : cfg.c_eff;
        addr_p    = PROD_W'(inner_reg) * PROD_W'(lo) + PROD_W'(outer_reg);
        addr_in   = addr_p < MAX_P;
        inner_wrap = ({1'b0, inner_reg} + CFG_W'(1)) >= li;
        outer_wrap = ({1'b0, outer_reg} + CFG_W'(1)) >= lo;
        do_load   = accept & (func == FUNC_LOAD) & frame_ok & ~ready_eff & (lc_p < MAX_P);
        do_fetch  = accept & (func == FUNC_FETCH) & frame_ok & ready_eff;
    end

    // Next state
    always_comb
    begin
        load_count_next  = load_count_reg;
        outer_next       = outer_reg;
        inner_next       = inner_reg;
        frame_ready_next = frame_ready_reg;
        if (accept)
        begin
            frame_ready_next = ready_eff;
        end
        if (do_load)
        begin
            load_count_next = load_count_reg + LCW'(1);
            if ((lc_p + PROD_W'(1)) >= cfg.total)
            begin
                frame_ready_next = 1'b1;
            end
        end
        if (do_fetch)
        begin
            priority if (inner_wrap && outer_wrap)
            begin
                inner_next       = '0;
                outer_next       = '0;
                load_count_next  = '0;
                frame_ready_next = 1'b0;
            end
            else if (inner_wrap)
            begin
                inner_next = '0;
                outer_next = outer_reg + CNT_W'(1);
            end
            else
            begin
                inner_next = inner_reg + CNT_W'(1);
            end
        end
    end

    // Store requests and result tag
    always_comb
    begin
        mem_we    = do_load;
        mem_waddr = load_count_reg[AW-1:0];
        mem_re    = do_fetch & addr_in;
        mem_raddr = addr_p[AW-1:0];
        res.last  = do_fetch & inner_wrap & outer_wrap;
        priority if (func == FUNC_LOAD)
        begin
            res.kind = RES_ZERO;
        end
        else if (!do_fetch)
        begin
            res.kind = RES_EMPTY;
        end
        else if (addr_in)
        begin
            res.kind = RES_DATA;
        end
        else
        begin
            res.kind = RES_ZERO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_count_reg  <= '0;
            outer_reg       <= '0;
            inner_reg       <= '0;
            frame_ready_reg <= 1'b0;
        end
        else
        begin
            load_count_reg  <= load_count_next;
            outer_reg       <= outer_next;
            inner_reg       <= inner_next;
            frame_ready_reg <= frame_ready_next;
        end
    end

endmodule

// ===== tb/tb_channel_position_transpose.sv =====
// tb_channel_position_transpose: self-checking bench for the corner-turn buffer.
// Drives load/fetch beats, predicts every output beat with its own frame store and walk
// counters, and checks each field. Depends on cpt_pkg and channel_position_transpose.
module tb_channel_position_transpose;
    import cpt_pkg::*;

    localparam int unsigned STORE_DEPTH    = 4096;
    localparam logic        MODE_CH_TO_POS = 1'b0;
    localparam logic        MODE_POS_TO_CH = 1'b1;
    localparam int unsigned RANDOM_WORDS   = 1200;
    localparam int unsigned QUIET_WORDS    = 300;
    localparam int unsigned CNT_MASK       = (1 << CNT_W) - 1;

    typedef struct packed {
        logic [OUT_W-1:0] data;
        logic             last;
        logic             empty;
    } turned_word_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic             func = FUNC_LOAD;
    logic [OUT_W-1:0] data_in = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [OUT_W-1:0] data_out;
    logic             last_of_frame;
    logic             empty_fetch;

    // Shadow copy of the buffer state and its configuration
    logic [OUT_W-1:0] frame_copy [STORE_DEPTH];
    int unsigned      fill_count = 0;
    int unsigned      walk_outer = 0;
    int unsigned      walk_inner = 0;
    bit               frame_full = 1'b0;
    logic             dir_mode = MODE_CH_TO_POS;
    logic [CFG_W-1:0] chan_cnt = CFG_W'(1);
    logic [CFG_W-1:0] pos_cnt = CFG_W'(1);

    turned_word_t     turned_words [$];
    int unsigned      words_moved = 0;
    int unsigned      fail_count = 0;
    bit               idle_en = 1'b1;
    int unsigned      hold_left = 0;
    int unsigned      stall_left = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    channel_position_transpose #(
        .MAX_ELEMENTS (STORE_DEPTH),
        .DATA_WIDTH   (OUT_W)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .data_in       (data_in),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .data_out      (data_out),
        .last_of_frame (last_of_frame),
        .empty_fetch   (empty_fetch)
    );

    // A count of zero behaves as one
    function automatic int unsigned eff_count(input logic [CFG_W-1:0] v);
        return (v == 0) ? 1 : v;
    endfunction

    function automatic int unsigned frame_words();
        return eff_count(chan_cnt) * eff_count(pos_cnt);
    endfunction

    // Frame is full, or will be marked full by the next beat
    function automatic bit frame_pending();
        return frame_words() <= STORE_DEPTH && (frame_full || fill_count >= frame_words());
    endfunction

    // Advance the shadow buffer by one input beat and return the output beat it causes
    function automatic turned_word_t corner_turn(input logic f, input logic [OUT_W-1:0] d);
        int unsigned  c;
        int unsigned  s;
        int unsigned  total;
        int unsigned  lo;
        int unsigned  li;
        int unsigned  addr;
        bit           fits;
        turned_word_t r;
        c     = eff_count(chan_cnt);
        s     = eff_count(pos_cnt);
        total = c * s;
        fits  = total <= STORE_DEPTH;
        r     = '0;
        if (fits && fill_count >= total)
            frame_full = 1'b1;

        // Loads store the next source word unless the frame is full or oversized
        if (f == FUNC_LOAD)
        begin
            if (fits && !frame_full && fill_count < STORE_DEPTH)
            begin
                frame_copy[fill_count] = d;
                fill_count++;
                words_moved++;
                if (fill_count >= total)
                    frame_full = 1'b1;
            end
            return r;
        end

        if (!fits || !frame_full)
        begin
            r.empty = 1'b1;
            return r;
        end

        // Transposed walk: inner counter steps the fast index of the output order
        lo   = (dir_mode == MODE_CH_TO_POS) ? s : c;
        li   = (dir_mode == MODE_CH_TO_POS) ? c : s;
        addr = walk_inner * lo + walk_outer;
        if (addr < STORE_DEPTH)
            r.data = frame_copy[addr];
        words_moved++;
        if (walk_inner + 1 >= li && walk_outer + 1 >= lo)
        begin
            r.last     = 1'b1;
            walk_inner = 0;
            walk_outer = 0;
            fill_count = 0;
            frame_full = 1'b0;
        end
        else if (walk_inner + 1 >= li)
        begin
            walk_inner = 0;
            walk_outer = (walk_outer + 1) & CNT_MASK;
        end
        else
            walk_inner = (walk_inner + 1) & CNT_MASK;
        return r;
    endfunction

    // Offer one beat, optionally after an idle burst, and log its prediction on accept
    task automatic send_beat(input logic f, input logic [OUT_W-1:0] d);
        int unsigned  gap;
        turned_word_t w;
        if (idle_en && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 9);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        data_in  <= d;
        do
            @(posedge clk);
        while (!in_ready);
        w = corner_turn(f, d);
        turned_words = {turned_words, w};
    endtask

    // Drop valid and wait until every predicted beat has come out
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (turned_words.size() != 0)
            @(posedge clk);
    endtask

    // Write all three registers on back-to-back cycles while the block is idle
    task automatic configure(input logic mode, input int unsigned chans,
                             input int unsigned spots);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_IDX_DIRECTION;
        cfg_data  <= CFG_W'(mode);
        @(posedge clk);
        cfg_index <= CFG_IDX_CHANNELS;
        cfg_data  <= CFG_W'(chans);
        @(posedge clk);
        cfg_index <= CFG_IDX_SPATIAL;
        cfg_data  <= CFG_W'(spots);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        dir_mode = mode;
        chan_cnt = CFG_W'(chans);
        pos_cnt  = CFG_W'(spots);
    endtask

    // Finish whatever frame is open: top up loads, then walk it to the last word
    task automatic close_frame();
        if (fill_count != 0 || frame_full)
        begin
            while (!frame_pending())
                send_beat(FUNC_LOAD, $urandom);
            while (frame_pending())
                send_beat(FUNC_FETCH, $urandom);
        end
    endtask

    // One full frame of random words; noisy adds early fetches and overfill loads
    task automatic run_frame(input bit noisy);
        int unsigned n;
        n = frame_words();
        repeat (n)
        begin
            if (noisy && $urandom_range(0, 15) == 0)
                send_beat(FUNC_FETCH, $urandom);
            send_beat(FUNC_LOAD, $urandom);
        end
        if (noisy && $urandom_range(0, 3) == 0)
            send_beat(FUNC_LOAD, $urandom);
        repeat (n)
            send_beat(FUNC_FETCH, $urandom);
    endtask

    // 1x1 frame: fetch while empty, load into a full buffer, fetch after the walk
    task automatic test_single_word();
        configure(MODE_CH_TO_POS, 1, 1);
        send_beat(FUNC_FETCH, 32'h0000_0000);
        send_beat(FUNC_LOAD, 32'hFFFF_FFFF);
        send_beat(FUNC_LOAD, 32'h0000_0000);
        send_beat(FUNC_FETCH, 32'hFFFF_FFFF);
        send_beat(FUNC_FETCH, 32'h0000_0000);
    endtask

    // Small frames in both directions with corner data patterns
    task automatic test_small_frames();
        logic [OUT_W-1:0] words [6] = '{32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0000,
                                        32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000};
        configure(MODE_CH_TO_POS, 2, 3);
        foreach (words[i])
            send_beat(FUNC_LOAD, words[i]);
        repeat (6)
            send_beat(FUNC_FETCH, 32'h0000_0000);
        configure(MODE_POS_TO_CH, 2, 2);
        for (int i = 0; i < 4; i++)
            send_beat(FUNC_LOAD, words[i + 2]);
        repeat (4)
            send_beat(FUNC_FETCH, 32'hFFFF_FFFF);
    endtask

    task automatic test_zero_counts();
        configure(MODE_POS_TO_CH, 0, 0);
        send_beat(FUNC_LOAD, $urandom);
        send_beat(FUNC_FETCH, $urandom);
    endtask

    // Frames over the store size drop loads and fetch empty; an exact fit keeps its load
    task automatic test_oversized();
        configure(MODE_CH_TO_POS, 4096, 4096);
        send_beat(FUNC_LOAD, $urandom);
        send_beat(FUNC_FETCH, $urandom);
        configure(MODE_POS_TO_CH, 8191, 8191);
        send_beat(FUNC_LOAD, $urandom);
        send_beat(FUNC_FETCH, $urandom);

        // one word over the store: the load is dropped
        configure(MODE_CH_TO_POS, 4097, 1);
        send_beat(FUNC_LOAD, $urandom);
        configure(MODE_CH_TO_POS, 1, 1);
        send_beat(FUNC_FETCH, $urandom);

        // exactly the store size: the load is kept
        configure(MODE_CH_TO_POS, 4096, 1);
        send_beat(FUNC_LOAD, $urandom);
        configure(MODE_CH_TO_POS, 1, 1);
        send_beat(FUNC_FETCH, $urandom);
    endtask

    // Size changes in the middle of a fill and in the middle of a walk
    task automatic test_midframe_config();
        configure(MODE_CH_TO_POS, 2, 4);
        repeat (6)
            send_beat(FUNC_LOAD, $urandom);
        configure(MODE_CH_TO_POS, 2, 3);
        close_frame();

        // shrink mid-walk: counters already at the last word of the new frame
        configure(MODE_CH_TO_POS, 4, 4);
        repeat (16)
            send_beat(FUNC_LOAD, $urandom);
        repeat (5)
            send_beat(FUNC_FETCH, $urandom);
        configure(MODE_POS_TO_CH, 2, 2);
        close_frame();

        // grow mid-walk: first read lands past the end of the store
        configure(MODE_CH_TO_POS, 16, 18);
        repeat (288)
            send_beat(FUNC_LOAD, $urandom);
        repeat (15)
            send_beat(FUNC_FETCH, $urandom);
        configure(MODE_CH_TO_POS, 1, 288);
        close_frame();
    endtask

    // Receiver holds off long enough for the block to fill and stall its input
    task automatic test_backpressure();
        configure(MODE_POS_TO_CH, 4, 4);
        hold_left <= 80;
        run_frame(1'b0);
    endtask

    // Mostly well-formed frames of random sizes, with some noise; quiet at the end
    task automatic test_random();
        int unsigned base;
        int unsigned chans;
        int unsigned spots;
        base = words_moved;
        while (words_moved - base < RANDOM_WORDS)
        begin
            idle_en = (words_moved - base + QUIET_WORDS < RANDOM_WORDS) &&
                      ($urandom_range(0, 3) != 0);
            close_frame();
            if ($urandom_range(0, 2) == 0)
            begin
                if ($urandom_range(0, 15) == 0)
                begin
                    chans = $urandom_range(1, 64);
                    spots = $urandom_range(1, 64);
                end
                else
                begin
                    chans = $urandom_range(0, 12);
                    spots = $urandom_range(0, 12);
                end
                configure(1'($urandom_range(0, 1)), chans, spots);
            end
            run_frame(1'b1);
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 4))
                    send_beat(1'($urandom_range(0, 1)), $urandom);
        end
        idle_en = 1'b0;
    endtask

    // Output side: check each accepted beat, then pick the next ready value
    always @(posedge clk)
    begin : rx
        turned_word_t want;
        if (out_valid && out_ready)
        begin
            if (turned_words.size() == 0)
            begin
                if (fail_count < 40)
                    $display("%0t: output beat with none expected: data %h last %b empty %b",
                             $time, data_out, last_of_frame, empty_fetch);
                fail_count++;
            end
            else
            begin
                want = turned_words.pop_front();
                if (data_out !== want.data || last_of_frame !== want.last ||
                    empty_fetch !== want.empty)
                begin
                    if (fail_count < 40)
                        $display("%0t: expected data %h last %b empty %b, got %h %b %b",
                                 $time, want.data, want.last, want.empty,
                                 data_out, last_of_frame, empty_fetch);
                    fail_count++;
                end
            end
        end

        // long hold first, then random stall bursts
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (stall_left != 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (idle_en && $urandom_range(0, 7) == 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 8);
        end
        else
            out_ready <= 1'b1;
    end

    initial
    begin
        foreach (frame_copy[i])
            frame_copy[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_single_word();
        test_small_frames();
        test_zero_counts();
        test_oversized();
        test_midframe_config();
        test_backpressure();
        test_random();

        wait_idle();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && turned_words.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog
    initial
    begin
        #30_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
